FILE: sv/gpt_pkg.sv
`default_nettype none

package gpt_pkg;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_WRITE   = 2'd2,
        CMD_CAPTURE = 2'd3
    } cmd_t;

    // register word indexes
    localparam logic [3:0] REG_CTRL     = 4'd0;
    localparam logic [3:0] REG_PRESCALE = 4'd1;
    localparam logic [3:0] REG_STATUS   = 4'd2;
    localparam logic [3:0] REG_IRQ_EN   = 4'd3;
    localparam logic [3:0] REG_CMP1     = 4'd4;
    localparam logic [3:0] REG_CMP2     = 4'd5;
    localparam logic [3:0] REG_CMP3     = 4'd6;
    localparam logic [3:0] REG_CAP1     = 4'd7;
    localparam logic [3:0] REG_CAP2     = 4'd8;
    localparam logic [3:0] REG_COUNT    = 4'd9;

    // control word fields
    localparam int CTRL_EN      = 0;
    localparam int CTRL_ENMOD   = 1;
    localparam int CTRL_SRC_LSB = 6;
    localparam int CTRL_FRR     = 9;
    localparam int CTRL_SWR     = 15;
    localparam int CTRL_IM_LSB  = 16;
    localparam int CTRL_OM_LSB  = 20;
    localparam int CTRL_FO1     = 29;
    localparam int CTRL_FO2     = 30;
    localparam int CTRL_FO3     = 31;
    // force-output and software reset bits are never stored
    localparam logic [31:0] CTRL_STORE_MASK = ~32'hE000_8000;

    localparam logic [2:0] SRC_OFF      = 3'd0;
    localparam logic [2:0] SRC_EXTERNAL = 3'd3;

    localparam logic [2:0] OM_NONE   = 3'd0;
    localparam logic [2:0] OM_TOGGLE = 3'd1;
    localparam logic [2:0] OM_SET    = 3'd3;

    // status bits
    localparam int ST_CMP1 = 0;
    localparam int ST_CAP1 = 3;
    localparam int ST_ROLL = 5;
    localparam int ST_W    = 6;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic        capture_channel;
        logic        capture_level;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic [2:0]  pins;
    } result_t;

    function automatic logic [2:0] out_mode(input logic [31:0] ctrl, input int ch);
        return ctrl[CTRL_OM_LSB + 3 * ch +: 3];
    endfunction

    // low pulse modes act as clear
    function automatic logic drive_pin(input logic level, input logic [2:0] mode);
        logic r;
        case (mode)
            OM_NONE:   r = level;
            OM_TOGGLE: r = ~level;
            OM_SET:    r = 1'b1;
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/gpt_req_if.sv
`default_nettype none

interface gpt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic        capture_channel;
    logic        capture_level;

    modport source (output valid, cmd, reg_index, write_data, capture_channel,
                    capture_level, input ready);
    modport sink   (input valid, cmd, reg_index, write_data, capture_channel,
                    capture_level, output ready);
endinterface

`default_nettype wire

FILE: sv/gpt_rsp_if.sv
`default_nettype none

interface gpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq;
    logic        compare_pin1;
    logic        compare_pin2;
    logic        compare_pin3;

    modport source (output valid, read_data, irq, compare_pin1, compare_pin2,
                    compare_pin3, input ready);
    modport sink   (input valid, read_data, irq, compare_pin1, compare_pin2,
                    compare_pin3, output ready);
endinterface

`default_nettype wire

FILE: sv/gpt_core.sv
`default_nettype none

module gpt_core #(
    parameter int PRESCALE_WRAP = 4096
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire gpt_pkg::item_t   item,
    output gpt_pkg::result_t      result
);

    localparam int PCW = $clog2(PRESCALE_WRAP + 1);

    logic [31:0]            main_count_reg,  main_count_next;
    logic [PCW-1:0]         pre_count_reg,   pre_count_next;
    logic [31:0]            ctrl_reg,        ctrl_next;
    logic [31:0]            pre_limit_reg,   pre_limit_next;
    logic [gpt_pkg::ST_W-1:0] status_reg,    status_next;
    logic [31:0]            irq_en_reg,      irq_en_next;
    logic [31:0]            cmp_reg [3];
    logic [31:0]            cmp_next [3];
    logic [31:0]            cap_reg [2];
    logic [31:0]            cap_next [2];
    logic [2:0]             pin_reg,         pin_next;
    logic                   irq_reg,         irq_next;
    logic [31:0]            rd;

    always_comb
    begin
        logic [2:0]  src;
        logic [1:0]  im;
        logic        hit;
        logic [31:0] c;
        logic [31:0] d;

        main_count_next = main_count_reg;
        pre_count_next  = pre_count_reg;
        ctrl_next       = ctrl_reg;
        pre_limit_next  = pre_limit_reg;
        status_next     = status_reg;
        irq_en_next     = irq_en_reg;
        cmp_next        = cmp_reg;
        cap_next        = cap_reg;
        pin_next        = pin_reg;
        irq_next        = irq_reg;
        rd              = '0;

        src = ctrl_reg[gpt_pkg::CTRL_SRC_LSB +: 3];
        c   = main_count_reg;
        d   = item.write_data;
        im  = item.capture_channel ? ctrl_reg[gpt_pkg::CTRL_IM_LSB + 2 +: 2]
                                   : ctrl_reg[gpt_pkg::CTRL_IM_LSB +: 2];
        hit = item.capture_level ? im[1] : im[0];

        case (item.cmd)
            gpt_pkg::CMD_TICK:
            begin
                if (ctrl_reg[gpt_pkg::CTRL_EN] && src != gpt_pkg::SRC_OFF
                    && src != gpt_pkg::SRC_EXTERNAL)
                begin
                    if ({{(32-PCW){1'b0}}, pre_count_reg} == pre_limit_reg)
                    begin
                        pre_count_next = '0;
                        if (c == '1)
                        begin
                            status_next[gpt_pkg::ST_ROLL] = 1'b1;
                        end
                        // compare 1 wins over 2, 2 over 3
                        if (c == cmp_reg[0])
                        begin
                            status_next[gpt_pkg::ST_CMP1] = 1'b1;
                            pin_next[0] = gpt_pkg::drive_pin(pin_reg[0],
                                              gpt_pkg::out_mode(ctrl_reg, 0));
                        end
                        else if (c == cmp_reg[1])
                        begin
                            status_next[gpt_pkg::ST_CMP1 + 1] = 1'b1;
                            pin_next[1] = gpt_pkg::drive_pin(pin_reg[1],
                                              gpt_pkg::out_mode(ctrl_reg, 1));
                        end
                        else if (c == cmp_reg[2])
                        begin
                            status_next[gpt_pkg::ST_CMP1 + 2] = 1'b1;
                            pin_next[2] = gpt_pkg::drive_pin(pin_reg[2],
                                              gpt_pkg::out_mode(ctrl_reg, 2));
                        end
                        if (!ctrl_reg[gpt_pkg::CTRL_FRR] && c == cmp_reg[0])
                        begin
                            main_count_next = '0;
                        end
                        else
                        begin
                            main_count_next = c + 32'd1;
                        end
                        irq_next = |(irq_en_reg & {{(32-gpt_pkg::ST_W){1'b0}}, status_next});
                    end
                    else if (pre_count_reg >= PCW'(PRESCALE_WRAP))
                    begin
                        pre_count_next = '0;
                    end
                    else
                    begin
                        pre_count_next = pre_count_reg + 1'b1;
                    end
                end
            end
            gpt_pkg::CMD_READ:
            begin
                unique case (item.reg_index)
                    gpt_pkg::REG_CTRL:     rd = ctrl_reg;
                    gpt_pkg::REG_PRESCALE: rd = pre_limit_reg;
                    gpt_pkg::REG_STATUS:   rd = {{(32-gpt_pkg::ST_W){1'b0}}, status_reg};
                    gpt_pkg::REG_IRQ_EN:   rd = irq_en_reg;
                    gpt_pkg::REG_CMP1:     rd = cmp_reg[0];
                    gpt_pkg::REG_CMP2:     rd = cmp_reg[1];
                    gpt_pkg::REG_CMP3:     rd = cmp_reg[2];
                    gpt_pkg::REG_CAP1:     rd = cap_reg[0];
                    gpt_pkg::REG_CAP2:     rd = cap_reg[1];
                    gpt_pkg::REG_COUNT:    rd = main_count_reg;
                    default:               rd = '0;
                endcase
            end
            gpt_pkg::CMD_WRITE:
            begin
                unique case (item.reg_index)
                    gpt_pkg::REG_CTRL:
                    begin
                        // forced outputs use the old modes
                        if (d[gpt_pkg::CTRL_FO3])
                            pin_next[2] = gpt_pkg::drive_pin(pin_reg[2],
                                              gpt_pkg::out_mode(ctrl_reg, 2));
                        if (d[gpt_pkg::CTRL_FO2])
                            pin_next[1] = gpt_pkg::drive_pin(pin_reg[1],
                                              gpt_pkg::out_mode(ctrl_reg, 1));
                        if (d[gpt_pkg::CTRL_FO1])
                            pin_next[0] = gpt_pkg::drive_pin(pin_reg[0],
                                              gpt_pkg::out_mode(ctrl_reg, 0));
                        if (!ctrl_reg[gpt_pkg::CTRL_EN] && d[gpt_pkg::CTRL_EN]
                            && d[gpt_pkg::CTRL_ENMOD])
                        begin
                            main_count_next = '0;
                            pre_count_next  = '0;
                        end
                        ctrl_next = d & gpt_pkg::CTRL_STORE_MASK;
                        if (d[gpt_pkg::CTRL_SWR])
                        begin
                            main_count_next = '0;
                            pre_count_next  = '0;
                            ctrl_next       = '0;
                            pre_limit_next  = '0;
                            status_next     = '0;
                            irq_en_next     = '0;
                            cmp_next        = '{default: '0};
                            cap_next        = '{default: '0};
                            pin_next        = '0;
                            irq_next        = 1'b0;
                        end
                    end
                    gpt_pkg::REG_PRESCALE:
                    begin
                        pre_limit_next = d;
                        pre_count_next = '0;
                    end
                    gpt_pkg::REG_STATUS:   status_next = status_reg & ~d[gpt_pkg::ST_W-1:0];
                    gpt_pkg::REG_IRQ_EN:   irq_en_next = d;
                    gpt_pkg::REG_CMP1:
                    begin
                        if (!ctrl_reg[gpt_pkg::CTRL_FRR])
                            main_count_next = '0;
                        cmp_next[0] = d;
                    end
                    gpt_pkg::REG_CMP2:     cmp_next[1] = d;
                    gpt_pkg::REG_CMP3:     cmp_next[2] = d;
                    default:               ;
                endcase
            end
            default:
            begin
                if (hit)
                begin
                    if (item.capture_channel)
                    begin
                        cap_next[1] = main_count_reg;
                        status_next[gpt_pkg::ST_CAP1 + 1] = 1'b1;
                    end
                    else
                    begin
                        cap_next[0] = main_count_reg;
                        status_next[gpt_pkg::ST_CAP1] = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_count_reg <= '0;
            pre_count_reg  <= '0;
            ctrl_reg       <= '0;
            pre_limit_reg  <= '0;
            status_reg     <= '0;
            irq_en_reg     <= '0;
            cmp_reg        <= '{default: '0};
            cap_reg        <= '{default: '0};
            pin_reg        <= '0;
            irq_reg        <= 1'b0;
        end
        else if (item_valid)
        begin
            main_count_reg <= main_count_next;
            pre_count_reg  <= pre_count_next;
            ctrl_reg       <= ctrl_next;
            pre_limit_reg  <= pre_limit_next;
            status_reg     <= status_next;
            irq_en_reg     <= irq_en_next;
            cmp_reg        <= cmp_next;
            cap_reg        <= cap_next;
            pin_reg        <= pin_next;
            irq_reg        <= irq_next;
        end
    end

    assign result.read_data = rd;
    assign result.irq       = irq_next;
    assign result.pins      = pin_next;

endmodule

`default_nettype wire

FILE: sv/general_purpose_timer.sv
// A word taken into the input register goes through the state update into the
// result register and out on rsp. Throughput: one word per cycle while rsp is
// ready; ticks, accesses and edges all take one pass through the state update.
// A stalled result is held while one more word waits in the input register.
// Reset (rst_n, async, active low) zeroes all timer state, pins and irq.
`default_nettype none

module general_purpose_timer #(
    parameter int PRESCALE_WRAP = 4096
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gpt_req_if.sink    req,
    gpt_rsp_if.source  rsp
);

    logic               req_valid_reg;
    gpt_pkg::item_t     item_reg;
    logic               rsp_valid_reg;
    gpt_pkg::result_t   result_reg;
    gpt_pkg::result_t   result_next;
    logic               advance;

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.cmd             <= gpt_pkg::cmd_t'(req.cmd);
            item_reg.reg_index       <= req.reg_index;
            item_reg.write_data      <= req.write_data;
            item_reg.capture_channel <= req.capture_channel;
            item_reg.capture_level   <= req.capture_level;
        end
    end

    gpt_core #(
        .PRESCALE_WRAP (PRESCALE_WRAP)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .item       (item_reg),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
            result_reg    <= result_next;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_data    = result_reg.read_data;
    assign rsp.irq          = result_reg.irq;
    assign rsp.compare_pin1 = result_reg.pins[0];
    assign rsp.compare_pin2 = result_reg.pins[1];
    assign rsp.compare_pin3 = result_reg.pins[2];

`ifndef SYNTH
    // a held word in the input register blocks new words
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !advance) |-> !req.ready)
        else $error("input register overrun");

    // only reads return data
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.cmd != gpt_pkg::CMD_READ) |=> (rsp.read_data == 32'd0))
        else $error("read_data nonzero for a non-read word");

    // reads never move irq or pins
    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.cmd == gpt_pkg::CMD_READ) |=>
        (rsp.irq == $past(rsp.irq) && rsp.compare_pin1 == $past(rsp.compare_pin1)
         && rsp.compare_pin2 == $past(rsp.compare_pin2)
         && rsp.compare_pin3 == $past(rsp.compare_pin3)))
        else $error("read changed irq or pins");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/general_purpose_timer_tb.sv
`timescale 1ns / 1ps

module general_purpose_timer_tb;
    import gpt_pkg::*;

    localparam int PS_WRAP     = 256;
    localparam int STALL_LIMIT = 2000;

    localparam logic [2:0] SRC_INTERNAL = 3'd1;
    localparam logic [2:0] SRC_LAST     = 3'd7;
    localparam logic [2:0] OM_CLEAR     = 3'd2;
    localparam logic [2:0] OM_LOW_PULSE = 3'd4;
    localparam logic [1:0] IM_OFF       = 2'd0;
    localparam logic [1:0] IM_RISING    = 2'd1;
    localparam logic [1:0] IM_FALLING   = 2'd2;
    localparam logic [1:0] IM_BOTH      = 2'd3;

    localparam logic [31:0] FORCE_ALL =
        (32'h1 << CTRL_FO1) | (32'h1 << CTRL_FO2) | (32'h1 << CTRL_FO3);
    localparam logic [31:0] SOFT_RESET = 32'h1 << CTRL_SWR;

    logic clk;
    logic rst_n;

    gpt_req_if req();
    gpt_rsp_if rsp();

    general_purpose_timer #(
        .PRESCALE_WRAP(PS_WRAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow copy of the timer state
    logic [31:0]     t_count;
    logic [12:0]     t_prescale;
    logic [31:0]     t_ctrl;
    logic [31:0]     t_limit;
    logic [ST_W-1:0] t_status;
    logic [31:0]     t_irq_en;
    logic [31:0]     t_cmp [3];
    logic [31:0]     t_cap [2];
    logic [2:0]      t_pins;
    logic            t_irq;

    result_t pending_results[$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_timer();
        t_count    = '0;
        t_prescale = '0;
        t_ctrl     = '0;
        t_limit    = '0;
        t_status   = '0;
        t_irq_en   = '0;
        t_cmp      = '{default: '0};
        t_cap      = '{default: '0};
        t_pins     = '0;
        t_irq      = 1'b0;
    endfunction

    function automatic void drive_compare_pin(input int ch, input logic [31:0] ctrl);
        logic [2:0] mode;
        mode = ctrl[CTRL_OM_LSB + 3 * ch +: 3];
        if (mode == OM_TOGGLE)
            t_pins[ch] = ~t_pins[ch];
        else if (mode == OM_SET)
            t_pins[ch] = 1'b1;
        else if (mode != OM_NONE)
            t_pins[ch] = 1'b0;
    endfunction

    function automatic void timer_tick();
        logic [2:0]  src;
        logic [31:0] c;
        src = t_ctrl[CTRL_SRC_LSB +: 3];
        if (!t_ctrl[CTRL_EN] || src == SRC_OFF || src == SRC_EXTERNAL)
            return;
        if ({19'd0, t_prescale} != t_limit)
        begin
            if (t_prescale >= PS_WRAP)
                t_prescale = '0;
            else
                t_prescale++;
            return;
        end
        t_prescale = '0;
        c = t_count;
        if (c == '1)
            t_status[ST_ROLL] = 1'b1;
        // compare 1 wins over 2, 2 over 3
        for (int ch = 0; ch < 3; ch++)
        begin
            if (c == t_cmp[ch])
            begin
                t_status[ST_CMP1 + ch] = 1'b1;
                drive_compare_pin(ch, t_ctrl);
                break;
            end
        end
        if (!t_ctrl[CTRL_FRR] && c == t_cmp[0])
            t_count = '0;
        else
            t_count = c + 32'd1;
        t_irq = |(t_irq_en[ST_W-1:0] & t_status);
    endfunction

    function automatic logic [31:0] timer_read(input logic [3:0] idx);
        case (idx)
            REG_CTRL:     return t_ctrl;
            REG_PRESCALE: return t_limit;
            REG_STATUS:   return {{(32 - ST_W){1'b0}}, t_status};
            REG_IRQ_EN:   return t_irq_en;
            REG_CMP1:     return t_cmp[0];
            REG_CMP2:     return t_cmp[1];
            REG_CMP3:     return t_cmp[2];
            REG_CAP1:     return t_cap[0];
            REG_CAP2:     return t_cap[1];
            REG_COUNT:    return t_count;
            default:      return '0;
        endcase
    endfunction

    function automatic void timer_write(input logic [3:0] idx, input logic [31:0] d);
        logic [31:0] old;
        old = t_ctrl;
        case (idx)
            REG_CTRL:
            begin
                // forced outputs follow the modes in force before this write
                if (d[CTRL_FO3])
                    drive_compare_pin(2, old);
                if (d[CTRL_FO2])
                    drive_compare_pin(1, old);
                if (d[CTRL_FO1])
                    drive_compare_pin(0, old);
                if (!old[CTRL_EN] && d[CTRL_EN] && d[CTRL_ENMOD])
                begin
                    t_count    = '0;
                    t_prescale = '0;
                end
                t_ctrl = d & CTRL_STORE_MASK;
                if (d[CTRL_SWR])
                    clear_timer();
            end
            REG_PRESCALE:
            begin
                t_limit    = d;
                t_prescale = '0;
            end
            REG_STATUS: t_status &= ~d[ST_W-1:0];
            REG_IRQ_EN: t_irq_en = d;
            REG_CMP1:
            begin
                if (!t_ctrl[CTRL_FRR])
                    t_count = '0;
                t_cmp[0] = d;
            end
            REG_CMP2: t_cmp[1] = d;
            REG_CMP3: t_cmp[2] = d;
            default: ;
        endcase
    endfunction

    function automatic void timer_capture(input int ch, input logic falling);
        logic [1:0] im;
        im = t_ctrl[CTRL_IM_LSB + 2 * ch +: 2];
        if (im == IM_BOTH || (falling ? im == IM_FALLING : im == IM_RISING))
        begin
            t_cap[ch] = t_count;
            t_status[ST_CAP1 + ch] = 1'b1;
        end
    endfunction

    function automatic result_t predict_timer_step(input item_t it);
        result_t r;
        r.read_data = '0;
        case (it.cmd)
            CMD_TICK:    timer_tick();
            CMD_READ:    r.read_data = timer_read(it.reg_index);
            CMD_WRITE:   timer_write(it.reg_index, it.write_data);
            CMD_CAPTURE: timer_capture(int'(it.capture_channel), it.capture_level);
            default: ;
        endcase
        r.irq  = t_irq;
        r.pins = t_pins;
        return r;
    endfunction

    function automatic logic [31:0] make_ctrl(input logic en, input logic enmod,
                                              input logic [2:0] src, input logic frr,
                                              input logic [1:0] im1, input logic [1:0] im2,
                                              input logic [2:0] om1, input logic [2:0] om2,
                                              input logic [2:0] om3);
        logic [31:0] c;
        c = '0;
        c[CTRL_EN]                 = en;
        c[CTRL_ENMOD]              = enmod;
        c[CTRL_SRC_LSB +: 3]       = src;
        c[CTRL_FRR]                = frr;
        c[CTRL_IM_LSB +: 2]        = im1;
        c[CTRL_IM_LSB + 2 +: 2]    = im2;
        c[CTRL_OM_LSB +: 3]        = om1;
        c[CTRL_OM_LSB + 3 +: 3]    = om2;
        c[CTRL_OM_LSB + 6 +: 3]    = om3;
        return c;
    endfunction

    // mostly ticks with the timer running, compares placed near the count
    function automatic item_t random_word();
        item_t      it;
        int         r;
        logic [2:0] src;
        it.reg_index       = 4'($urandom);
        it.write_data      = $urandom;
        it.capture_channel = 1'($urandom);
        it.capture_level   = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55)
            it.cmd = CMD_TICK;
        else if (r < 70)
            it.cmd = CMD_READ;
        else if (r < 90)
        begin
            it.cmd = CMD_WRITE;
            if ($urandom_range(0, 4) != 0)
                it.reg_index = 4'($urandom_range(0, 6));
            case (it.reg_index)
                REG_CTRL:
                begin
                    if ($urandom_range(0, 39) != 0)
                        it.write_data[CTRL_SWR] = 1'b0;
                    if ($urandom_range(0, 7) != 0)
                    begin
                        src = 3'($urandom_range(1, 6));
                        if (src >= SRC_EXTERNAL)
                            src++;
                        it.write_data[CTRL_EN] = 1'b1;
                        it.write_data[CTRL_SRC_LSB +: 3] = src;
                    end
                end
                REG_PRESCALE:
                    if ($urandom_range(0, 19) != 0)
                        it.write_data = $urandom_range(0, 3);
                REG_CMP1, REG_CMP2, REG_CMP3:
                    if ($urandom_range(0, 9) != 0)
                        it.write_data = t_count + 32'($urandom_range(0, 6));
                default: ;
            endcase
        end
        else
            it.cmd = CMD_CAPTURE;
        return it;
    endfunction

    task automatic send_word(input item_t it);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            if (req.valid)
                req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.cmd             <= it.cmd;
        req.reg_index       <= it.reg_index;
        req.write_data      <= it.write_data;
        req.capture_channel <= it.capture_channel;
        req.capture_level   <= it.capture_level;
        do
            @(posedge clk);
        while (!req.ready);
        pending_results.push_back(predict_timer_step(it));
        words_sent++;
    endtask

    task automatic drain_results();
        if (req.valid)
            req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic tick_n(input int n);
        item_t it;
        it     = '0;
        it.cmd = CMD_TICK;
        repeat (n) send_word(it);
    endtask

    task automatic read_reg(input logic [3:0] idx);
        item_t it;
        it           = '0;
        it.cmd       = CMD_READ;
        it.reg_index = idx;
        send_word(it);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        item_t it;
        it            = '0;
        it.cmd        = CMD_WRITE;
        it.reg_index  = idx;
        it.write_data = data;
        send_word(it);
    endtask

    task automatic pin_edge(input logic ch, input logic falling);
        item_t it;
        it                 = '0;
        it.cmd             = CMD_CAPTURE;
        it.capture_channel = ch;
        it.capture_level   = falling;
        send_word(it);
    endtask

    task automatic check_timer_result();
        result_t exp;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: rd=%h irq=%b pins=%b", rsp.read_data,
                         rsp.irq, {rsp.compare_pin3, rsp.compare_pin2, rsp.compare_pin1});
            return;
        end
        exp = pending_results.pop_front();
        if (rsp.read_data !== exp.read_data || rsp.irq !== exp.irq ||
            rsp.compare_pin1 !== exp.pins[0] || rsp.compare_pin2 !== exp.pins[1] ||
            rsp.compare_pin3 !== exp.pins[2])
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d mismatch: expected rd=%h irq=%b pins=%b, got rd=%h irq=%b pins=%b",
                         results_seen, exp.read_data, exp.irq, exp.pins, rsp.read_data,
                         rsp.irq, {rsp.compare_pin3, rsp.compare_pin2, rsp.compare_pin1});
        end
    endtask

    always @(posedge clk)
        rsp.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (rsp.valid && rsp.ready)
                check_timer_result();
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic test_register_access();
        for (int i = 0; i < 16; i++)
            read_reg(4'(i));
        // includes unused and read-only indexes
        for (int i = 1; i < 16; i++)
        begin
            write_reg(4'(i), '1);
            read_reg(4'(i));
        end
        write_reg(REG_CTRL, ~SOFT_RESET);
        read_reg(REG_CTRL);
        read_reg(REG_COUNT);
        write_reg(REG_CTRL, SOFT_RESET);
        for (int i = 0; i < 10; i++)
            read_reg(4'(i));
    endtask

    task automatic test_compare_outputs();
        write_reg(REG_IRQ_EN, '1);
        write_reg(REG_PRESCALE, 32'd1);
        write_reg(REG_CMP2, 32'd1);
        write_reg(REG_CMP3, 32'd2);
        write_reg(REG_CMP1, 32'd4);
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b0, SRC_INTERNAL, 1'b0, IM_OFF, IM_OFF,
                                      OM_TOGGLE, OM_SET, OM_LOW_PULSE));
        tick_n(16);
        read_reg(REG_STATUS);
        read_reg(REG_COUNT);
        write_reg(REG_STATUS, 32'h1 << ST_CMP1);
        read_reg(REG_STATUS);
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b0, SRC_LAST, 1'b1, IM_OFF, IM_OFF,
                                      OM_CLEAR, OM_NONE, OM_SET));
        tick_n(12);
        read_reg(REG_COUNT);
        // irq drops only on the next prescaled tick
        write_reg(REG_STATUS, '1);
        tick_n(3);
    endtask

    task automatic test_input_capture();
        write_reg(REG_PRESCALE, '0);
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b0, SRC_INTERNAL, 1'b1, IM_RISING, IM_BOTH,
                                      OM_NONE, OM_NONE, OM_NONE));
        tick_n(3);
        pin_edge(1'b0, 1'b0);
        pin_edge(1'b0, 1'b1);
        tick_n(2);
        pin_edge(1'b1, 1'b0);
        tick_n(1);
        pin_edge(1'b1, 1'b1);
        read_reg(REG_CAP1);
        read_reg(REG_CAP2);
        read_reg(REG_STATUS);
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b0, SRC_INTERNAL, 1'b1, IM_FALLING, IM_OFF,
                                      OM_NONE, OM_NONE, OM_NONE));
        tick_n(2);
        pin_edge(1'b0, 1'b0);
        pin_edge(1'b0, 1'b1);
        pin_edge(1'b1, 1'b0);
        pin_edge(1'b1, 1'b1);
        read_reg(REG_CAP1);
        read_reg(REG_CAP2);
    endtask

    task automatic test_force_and_reenable();
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b1, SRC_INTERNAL, 1'b1, IM_OFF, IM_OFF,
                                      OM_TOGGLE, OM_SET, OM_CLEAR));
        tick_n(5);
        write_reg(REG_CTRL, FORCE_ALL | make_ctrl(1'b0, 1'b1, SRC_INTERNAL, 1'b1, IM_OFF,
                                                  IM_OFF, OM_TOGGLE, OM_SET, OM_CLEAR));
        read_reg(REG_COUNT);
        // new modes in the same write must not apply to the force
        write_reg(REG_CTRL, FORCE_ALL | make_ctrl(1'b1, 1'b0, SRC_INTERNAL, 1'b1, IM_OFF,
                                                  IM_OFF, OM_SET, OM_CLEAR, OM_TOGGLE));
        read_reg(REG_COUNT);
        write_reg(REG_CTRL, make_ctrl(1'b0, 1'b0, SRC_INTERNAL, 1'b1, IM_OFF, IM_OFF,
                                      OM_SET, OM_CLEAR, OM_TOGGLE));
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b1, SRC_INTERNAL, 1'b1, IM_OFF, IM_OFF,
                                      OM_SET, OM_CLEAR, OM_TOGGLE));
        read_reg(REG_COUNT);
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b0, SRC_EXTERNAL, 1'b1, IM_OFF, IM_OFF,
                                      OM_NONE, OM_NONE, OM_NONE));
        tick_n(3);
        read_reg(REG_COUNT);
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b0, SRC_OFF, 1'b1, IM_OFF, IM_OFF,
                                      OM_NONE, OM_NONE, OM_NONE));
        tick_n(3);
        read_reg(REG_COUNT);
        // get irq and compare pin 1 high, then wipe everything with a software reset
        write_reg(REG_IRQ_EN, '1);
        write_reg(REG_CMP1, '0);
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b0, SRC_INTERNAL, 1'b0, IM_OFF, IM_OFF,
                                      OM_SET, OM_NONE, OM_NONE));
        tick_n(4);
        write_reg(REG_CTRL, SOFT_RESET | make_ctrl(1'b1, 1'b0, SRC_INTERNAL, 1'b0, IM_BOTH,
                                                   IM_BOTH, OM_SET, OM_SET, OM_SET));
        read_reg(REG_CTRL);
        read_reg(REG_IRQ_EN);
    endtask

    task automatic test_prescaler_runaway();
        write_reg(REG_CTRL, make_ctrl(1'b1, 1'b0, SRC_INTERNAL, 1'b1, IM_OFF, IM_OFF,
                                      OM_NONE, OM_NONE, OM_NONE));
        write_reg(REG_PRESCALE, 32'd5000);
        tick_n(PS_WRAP + 3);
        read_reg(REG_COUNT);
        write_reg(REG_PRESCALE, 32'(PS_WRAP));
        tick_n(PS_WRAP + 2);
        read_reg(REG_COUNT);
    endtask

    task automatic test_random_traffic(input int n, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) send_word(random_word());
        drain_results();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        req.valid           = 1'b0;
        req.cmd             = CMD_TICK;
        req.reg_index       = '0;
        req.write_data      = '0;
        req.capture_channel = 1'b0;
        req.capture_level   = 1'b0;
        rsp.ready           = 1'b0;
        clear_timer();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_compare_outputs();
        test_input_capture();
        test_force_and_reenable();
        test_prescaler_runaway();
        drain_results();

        test_random_traffic(330, 0, 0);
        test_random_traffic(330, 81, 0);
        test_random_traffic(330, 0, 81);
        test_random_traffic(330, 9, 9);

        drain_results();
        repeat (4) @(posedge clk);

        $display("Covered register access, compare pin modes, capture edges, forced outputs,");
        $display("re-enable, soft reset, prescaler wrap and random traffic: %0d words, %0d results",
                 words_sent, results_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
